// File: hw/rtl/protobuf_wire_tokenizer_unit_macros.svh
// Assertion macros for the protobuf wire tokenizer unit.
`ifndef PROTOBUF_WIRE_TOKENIZER_UNIT_MACROS_SVH
`define PROTOBUF_WIRE_TOKENIZER_UNIT_MACROS_SVH

// Property must hold on every rising clock edge out of reset.
`define PWT_ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen on a rising clock edge out of reset.
`define PWT_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: hw/rtl/pwt_pkg.sv
// Shared constants and types of the protobuf wire tokenizer unit.
`timescale 1ns / 1ps

package pwt_pkg;

  localparam int unsigned MAX_MESSAGE_BYTES = 65536;
  localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Token kinds
  localparam logic [2:0] KIND_VARINT  = 3'd0;
  localparam logic [2:0] KIND_FIXED64 = 3'd1;
  localparam logic [2:0] KIND_LEN_HDR = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_FIXED32 = 3'd4;
  localparam logic [2:0] KIND_END     = 3'd5;

  // End-of-message status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNCATED = 3'd1;
  localparam logic [2:0] ST_BAD_WIRE  = 3'd2;
  localparam logic [2:0] ST_TOO_LONG  = 3'd3;
  localparam logic [2:0] ST_OVERRUN   = 3'd4;

  // Wire types
  localparam logic [2:0] WT_VARINT  = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  // Everything one input byte produces: an optional data token, an optional end token.
  typedef struct packed {
    logic        has_data;
    logic [2:0]  kind;
    logic [31:0] field;
    logic [2:0]  wtype;
    logic [63:0] value;
    logic        has_end;
    logic [2:0]  status;
  } tok_entry_t;

endpackage

// File: hw/rtl/pwt_front.sv
// Front end: parses one byte per cycle while the queue has room and queues the tokens it yields.
`timescale 1ns / 1ps

module pwt_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [7:0]          byte_in_i,
  input  logic                last_byte_i,
  input  logic                q_full_i,
  output logic                in_ready_o,
  output logic                push_o,
  output pwt_pkg::tok_entry_t entry_o
);

  typedef enum logic [2:0] {
    PH_KEY, PH_VARINT, PH_FIX64, PH_LEN, PH_PAYLOAD, PH_FIX32, PH_SKIP
  } phase_e;

  localparam logic [pwt_pkg::POS_W-1:0] MaxPos = pwt_pkg::POS_W'(pwt_pkg::MAX_MESSAGE_BYTES);

  phase_e                     phase_q, phase_d;
  logic [63:0]                acc_q, acc_d;
  logic [3:0]                 cnt_q, cnt_d;
  logic [31:0]                field_q, field_d;
  logic [2:0]                 wtype_q, wtype_d;
  logic [pwt_pkg::POS_W-1:0]  left_q, left_d;
  logic [pwt_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [2:0]                 err_q, err_d;

  logic                       accept;
  logic                       ovf;
  logic [5:0]                 shamt7;
  logic [63:0]                acc_var, acc_fix;
  logic [3:0]                 cnt_inc;
  logic                       vdone, vlong;
  logic [pwt_pkg::POS_W-1:0]  pos_inc, room;
  logic                       len_big;
  logic [2:0]                 end_st;
  pwt_pkg::tok_entry_t        entry;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    field_d = field_q;
    wtype_d = wtype_q;
    left_d  = left_q;
    pos_d   = pos_q;
    err_d   = err_q;
    entry   = '0;
    end_st  = pwt_pkg::ST_OK;

    // 7 * count, wrapped to a 64-bit shift
    shamt7  = 6'(({3'b000, cnt_q} << 3) - {3'b000, cnt_q});
    acc_var = acc_q | ({57'd0, byte_in_i[6:0]} << shamt7);
    acc_fix = acc_q | ({56'd0, byte_in_i} << {cnt_q[2:0], 3'b000});
    cnt_inc = cnt_q + 4'd1;
    vdone   = !byte_in_i[7];
    vlong   = byte_in_i[7] && (cnt_inc >= 4'd10);
    pos_inc = pos_q + 1'b1;
    room    = MaxPos - pos_inc;
    len_big = (acc_var[63:pwt_pkg::POS_W] != '0) || (acc_var[pwt_pkg::POS_W-1:0] > room);
    ovf     = (phase_q != PH_SKIP) && (pos_q >= MaxPos);

    if (accept) begin
      if (ovf) begin
        err_d   = pwt_pkg::ST_OVERRUN;
        phase_d = PH_SKIP;
      end else if (phase_q != PH_SKIP) begin
        pos_d = pos_inc;
      end

      if (!ovf) begin
        case (phase_q)
          PH_KEY: begin
            if (vlong) begin
              err_d   = pwt_pkg::ST_TOO_LONG;
              phase_d = PH_SKIP;
            end else if (vdone) begin
              field_d = acc_var[34:3];
              wtype_d = acc_var[2:0];
              acc_d   = '0;
              cnt_d   = '0;
              case (acc_var[2:0])
                pwt_pkg::WT_VARINT:  phase_d = PH_VARINT;
                pwt_pkg::WT_FIXED64: phase_d = PH_FIX64;
                pwt_pkg::WT_LEN:     phase_d = PH_LEN;
                pwt_pkg::WT_FIXED32: phase_d = PH_FIX32;
                default: begin
                  err_d   = pwt_pkg::ST_BAD_WIRE;
                  phase_d = PH_SKIP;
                end
              endcase
            end else begin
              acc_d = acc_var;
              cnt_d = cnt_inc;
            end
          end
          PH_VARINT: begin
            if (vlong) begin
              err_d   = pwt_pkg::ST_TOO_LONG;
              phase_d = PH_SKIP;
            end else if (vdone) begin
              entry.has_data = 1'b1;
              entry.kind     = pwt_pkg::KIND_VARINT;
              entry.value    = acc_var;
              acc_d          = '0;
              cnt_d          = '0;
              phase_d        = PH_KEY;
            end else begin
              acc_d = acc_var;
              cnt_d = cnt_inc;
            end
          end
          PH_LEN: begin
            if (vlong) begin
              err_d   = pwt_pkg::ST_TOO_LONG;
              phase_d = PH_SKIP;
            end else if (vdone) begin
              acc_d = '0;
              cnt_d = '0;
              if (len_big) begin
                err_d   = pwt_pkg::ST_OVERRUN;
                phase_d = PH_SKIP;
              end else begin
                entry.has_data = 1'b1;
                entry.kind     = pwt_pkg::KIND_LEN_HDR;
                entry.value    = acc_var;
                left_d         = acc_var[pwt_pkg::POS_W-1:0];
                phase_d        = (acc_var == '0) ? PH_KEY : PH_PAYLOAD;
              end
            end else begin
              acc_d = acc_var;
              cnt_d = cnt_inc;
            end
          end
          PH_PAYLOAD: begin
            entry.has_data = 1'b1;
            entry.kind     = pwt_pkg::KIND_PAYLOAD;
            entry.value    = {56'd0, byte_in_i};
            left_d         = left_q - 1'b1;
            if (left_q <= pwt_pkg::POS_W'(1)) begin
              left_d  = '0;
              phase_d = PH_KEY;
            end
          end
          PH_FIX64, PH_FIX32: begin
            acc_d = acc_fix;
            cnt_d = cnt_inc;
            if (cnt_inc >= ((phase_q == PH_FIX64) ? 4'd8 : 4'd4)) begin
              entry.has_data = 1'b1;
              entry.kind     = (phase_q == PH_FIX64) ? pwt_pkg::KIND_FIXED64
                                                     : pwt_pkg::KIND_FIXED32;
              entry.value    = acc_fix;
              acc_d          = '0;
              cnt_d          = '0;
              phase_d        = PH_KEY;
            end
          end
          default: ;
        endcase
      end

      entry.field = field_q;
      entry.wtype = wtype_q;

      if (last_byte_i) begin
        if (err_d != pwt_pkg::ST_OK) begin
          end_st = err_d;
        end else if (phase_d == PH_PAYLOAD) begin
          end_st = pwt_pkg::ST_OVERRUN;
        end else if (phase_d == PH_KEY && cnt_d == '0) begin
          end_st = pwt_pkg::ST_OK;
        end else begin
          end_st = pwt_pkg::ST_TRUNCATED;
        end
        entry.has_end = 1'b1;
        entry.status  = end_st;
        phase_d = PH_KEY;
        acc_d   = '0;
        cnt_d   = '0;
        field_d = '0;
        wtype_d = '0;
        left_d  = '0;
        pos_d   = '0;
        err_d   = pwt_pkg::ST_OK;
      end
    end
  end

  assign push_o  = accept && (entry.has_data || entry.has_end);
  assign entry_o = entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_KEY;
      acc_q   <= '0;
      cnt_q   <= '0;
      field_q <= '0;
      wtype_q <= '0;
      left_q  <= '0;
      pos_q   <= '0;
      err_q   <= pwt_pkg::ST_OK;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      field_q <= field_d;
      wtype_q <= wtype_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      err_q   <= err_d;
    end
  end

endmodule

// File: hw/rtl/pwt_queue.sv
// Short token queue between the parser and the output stage.
`timescale 1ns / 1ps

module pwt_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pwt_pkg::tok_entry_t entry_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output pwt_pkg::tok_entry_t entry_o
);

  pwt_pkg::tok_entry_t         slots_q [pwt_pkg::QUEUE_DEPTH];
  logic [pwt_pkg::QPTR_W-1:0]  wr_q, rd_q;
  logic [pwt_pkg::QCNT_W-1:0]  cnt_q;

  assign full_o  = (cnt_q == pwt_pkg::QCNT_W'(pwt_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/pwt_back.sv
// Output stage: splits queued entries into single tokens on a registered port.
`timescale 1ns / 1ps

module pwt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  pwt_pkg::tok_entry_t q_entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          token_kind_o,
  output logic [31:0]         field_id_o,
  output logic [2:0]          wire_code_o,
  output logic [63:0]         value_o,
  output logic [2:0]          status_o,
  output logic                last_result_o
);

  logic        valid_q;
  logic        pend_end_q;
  logic [2:0]  pend_st_q;
  logic [2:0]  kind_q;
  logic [31:0] field_q;
  logic [2:0]  wtype_q;
  logic [63:0] value_q;
  logic [2:0]  status_q;
  logic        last_q;
  logic        load;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = load && !pend_end_q && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      pend_end_q <= 1'b0;
    end else if (load) begin
      if (pend_end_q) begin
        valid_q    <= 1'b1;
        pend_end_q <= 1'b0;
      end else if (q_valid_i) begin
        valid_q    <= 1'b1;
        pend_end_q <= q_entry_i.has_data && q_entry_i.has_end;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (pend_end_q || (q_valid_i && !q_entry_i.has_data)) begin
        kind_q   <= pwt_pkg::KIND_END;
        field_q  <= '0;
        wtype_q  <= '0;
        value_q  <= '0;
        status_q <= pend_end_q ? pend_st_q : q_entry_i.status;
        last_q   <= 1'b1;
      end else begin
        kind_q   <= q_entry_i.kind;
        field_q  <= q_entry_i.field;
        wtype_q  <= q_entry_i.wtype;
        value_q  <= q_entry_i.value;
        status_q <= pwt_pkg::ST_OK;
        last_q   <= 1'b0;
      end
      if (pop_o) begin
        pend_st_q <= q_entry_i.status;
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign token_kind_o   = kind_q;
  assign field_id_o     = field_q;
  assign wire_code_o    = wtype_q;
  assign value_o        = value_q;
  assign status_o       = status_q;
  assign last_result_o  = last_q;

endmodule

// File: hw/rtl/protobuf_wire_tokenizer_unit.sv
// Protobuf wire-format tokenizer: one message byte in, field tokens out.
// Path: a completed token is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while the token queue has room; the final byte may owe
//   two tokens, which leave one after the other through the single output register.
// Reset: rst_ni is asynchronous, active low; clears parser state, queue and output valid.
`timescale 1ns / 1ps

`include "protobuf_wire_tokenizer_unit_macros.svh"

module protobuf_wire_tokenizer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  input  logic        last_byte_i,
  // token output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  token_kind_o,
  output logic [31:0] field_id_o,
  output logic [2:0]  wire_code_o,
  output logic [63:0] value_o,
  output logic [2:0]  status_o,
  output logic        last_result_o
);

  // Parser to queue
  logic                q_push;
  logic                q_full;
  pwt_pkg::tok_entry_t q_in_entry;

  // Queue to output stage
  logic                q_valid;
  logic                q_pop;
  pwt_pkg::tok_entry_t q_out_entry;

  // Front end: track the parse phase, build varints and fixed words, and
  // classify each byte into at most one data token plus the end token.
  // Ready depends only on queue room, so the parser waits on the output only through a full queue.
  pwt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .byte_in_i   (byte_in_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .in_ready_o  (in_ready_o),
    .push_o      (q_push),
    .entry_o     (q_in_entry)
  );

  // Decouple parser and output: absorb the extra output slot an end token costs.
  pwt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in_entry),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (q_out_entry)
  );

  // Back end: drain entries one token at a time into the output register; an entry holding
  // both a data token and the end token is popped with its data token, the end token held pending.
  pwt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_out_entry),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .field_id_o    (field_id_o),
    .wire_code_o   (wire_code_o),
    .value_o       (value_o),
    .status_o      (status_o),
    .last_result_o (last_result_o)
  );

  // A full queue must hold off the parser.
  `PWT_ASSERT_NEVER(a_no_push_when_full, q_push && q_full, "token queue overflow")

  // The final byte of a message always queues its end token.
  `PWT_ASSERT_PROP(a_last_byte_queues_end, (in_valid_i && in_ready_o && last_byte_i) |-> (q_push && q_in_entry.has_end), "final byte queued no end token")

  // Data tokens carry an OK status and never the end kind.
  `PWT_ASSERT_PROP(a_data_token_clean, (out_valid_o && !last_result_o) |-> (status_o == pwt_pkg::ST_OK && token_kind_o != pwt_pkg::KIND_END), "data token with end kind or error status")

endmodule

// File: test/testbench.sv
// Self-checking testbench for the protobuf wire tokenizer unit.
`timescale 1ns / 1ps

module testbench;
  import pwt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned RANDOM_BYTES = 1150;
  localparam int unsigned TAIL_CYCLES  = 8;

  // Wire types the tokenizer must reject (group start/end and the two reserved codes).
  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END   = 3'd4;
  localparam logic [2:0] WT_RESERVED6   = 3'd6;
  localparam logic [2:0] WT_RESERVED7   = 3'd7;

  // Tracks the parser state byte by byte and holds the tokens still owed by the block.
  class token_tracker;
    typedef enum logic [2:0] {
      P_KEY, P_VARINT, P_FIX64, P_LEN, P_PAYLOAD, P_FIX32, P_SKIP
    } phase_e;

    typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] fnum;
      logic [2:0]  wtype;
      logic [63:0] value;
      logic [2:0]  status;
      logic        last;
    } token_t;

    token_t      tokens_due[$];
    int unsigned errors;
    int unsigned checked;

    phase_e      ph;
    logic [63:0] acc;
    int unsigned nb;
    logic [31:0] fnum;
    logic [2:0]  wtype;
    int unsigned left;
    int unsigned pos;
    logic [2:0]  err;

    function new();
      restart();
      errors  = 0;
      checked = 0;
    endfunction

    function void restart();
      ph    = P_KEY;
      acc   = '0;
      nb    = 0;
      fnum  = '0;
      wtype = '0;
      left  = 0;
      pos   = 0;
      err   = ST_OK;
    endfunction

    function void abort(logic [2:0] code);
      err = code;
      ph  = P_SKIP;
    endfunction

    function void queue_token(logic [2:0] kind, logic [31:0] fn, logic [2:0] wt,
                              logic [63:0] val, logic [2:0] st, logic lst);
      tokens_due.push_back('{kind, fn, wt, val, st, lst});
    endfunction

    // 1: varint complete, 0: more bytes follow, -1: tenth byte still continues.
    function int absorb_varint(logic [7:0] b);
      acc |= 64'(b[6:0]) << ((7 * nb) & 63);
      nb++;
      if (!b[7]) return 1;
      if (nb >= 10) return -1;
      return 0;
    endfunction

    function void absorb_fixed(logic [7:0] b);
      acc |= 64'(b) << ((8 * nb) & 63);
      nb++;
    endfunction

    function void take_byte(logic [7:0] b, logic lst);
      int          r;
      logic [2:0]  st;
      logic [63:0] len;
      if (ph != P_SKIP) begin
        if (pos >= MAX_MESSAGE_BYTES) abort(ST_OVERRUN);
        else pos++;
      end
      case (ph)
        P_KEY: begin
          r = absorb_varint(b);
          if (r < 0) begin
            abort(ST_TOO_LONG);
          end else if (r > 0) begin
            fnum  = acc[34:3];
            wtype = acc[2:0];
            acc   = '0;
            nb    = 0;
            case (wtype)
              WT_VARINT:  ph = P_VARINT;
              WT_FIXED64: ph = P_FIX64;
              WT_LEN:     ph = P_LEN;
              WT_FIXED32: ph = P_FIX32;
              default:    abort(ST_BAD_WIRE);
            endcase
          end
        end
        P_VARINT: begin
          r = absorb_varint(b);
          if (r < 0) begin
            abort(ST_TOO_LONG);
          end else if (r > 0) begin
            queue_token(KIND_VARINT, fnum, wtype, acc, ST_OK, 1'b0);
            acc = '0;
            nb  = 0;
            ph  = P_KEY;
          end
        end
        P_LEN: begin
          r = absorb_varint(b);
          if (r < 0) begin
            abort(ST_TOO_LONG);
          end else if (r > 0) begin
            len = acc;
            acc = '0;
            nb  = 0;
            if (len > 64'(MAX_MESSAGE_BYTES - pos)) begin
              abort(ST_OVERRUN);
            end else begin
              queue_token(KIND_LEN_HDR, fnum, wtype, len, ST_OK, 1'b0);
              left = int'(len[31:0]);
              ph   = (len == 0) ? P_KEY : P_PAYLOAD;
            end
          end
        end
        P_PAYLOAD: begin
          queue_token(KIND_PAYLOAD, fnum, wtype, 64'(b), ST_OK, 1'b0);
          if (left > 0) left--;
          if (left == 0) ph = P_KEY;
        end
        P_FIX64, P_FIX32: begin
          absorb_fixed(b);
          if (nb >= ((ph == P_FIX64) ? 8 : 4)) begin
            queue_token((ph == P_FIX64) ? KIND_FIXED64 : KIND_FIXED32, fnum, wtype, acc,
                        ST_OK, 1'b0);
            acc = '0;
            nb  = 0;
            ph  = P_KEY;
          end
        end
        default: ;
      endcase
      if (lst) begin
        if (err != ST_OK) st = err;
        else if (ph == P_PAYLOAD) st = ST_OVERRUN;
        else if (ph == P_KEY && nb == 0) st = ST_OK;
        else st = ST_TRUNCATED;
        queue_token(KIND_END, '0, '0, '0, st, 1'b1);
        restart();
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: token %0d %s mismatch: expected %0h, got %0h",
                 $time, checked, name, want, got);
        errors++;
      end
    endfunction

    function void check_token(logic [2:0] kind, logic [31:0] fn, logic [2:0] wt,
                              logic [63:0] val, logic [2:0] st, logic lst);
      token_t want;
      if (tokens_due.size() == 0) begin
        $display("%0t: unexpected token: expected none, got kind %0h field %0h value %0h",
                 $time, kind, fn, val);
        errors++;
        return;
      end
      want = tokens_due.pop_front();
      compare("token_kind", want.kind, kind);
      compare("field_id", want.fnum, fn);
      compare("wire_code", want.wtype, wt);
      compare("value", want.value, val);
      compare("status", want.status, st);
      compare("last_result", want.last, lst);
      checked++;
    endfunction
  endclass

  // Drive every input to a known level from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  byte_in_i   = '0;
  logic        last_byte_i = 1'b0;
  logic        out_ready_i = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  token_kind_o;
  logic [31:0] field_id_o;
  logic [2:0]  wire_code_o;
  logic [63:0] value_o;
  logic [2:0]  status_o;
  logic        last_result_o;

  token_tracker tracker = new();
  logic [7:0]   msg_q[$];
  bit           src_idle    = 1'b1;
  bit           sink_idle   = 1'b1;
  int unsigned  stall_left  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  random_sent = 0;

  protobuf_wire_tokenizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .byte_in_i     (byte_in_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .field_id_o    (field_id_o),
    .wire_code_o   (wire_code_o),
    .value_o       (value_o),
    .status_o      (status_o),
    .last_result_o (last_result_o)
  );

  // 12 ns clock: low half, then high half.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long; nothing when idling is off.
  function automatic int unsigned pick_gap(bit on);
    int unsigned r;
    if (!on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Token sink: hold ready low for a random stall, then take one beat.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      out_ready_i = 1'b1;
      stall_left  = pick_gap(sink_idle);
    end
  end

  // Sample accepted tokens at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i)
      tracker.check_token(token_kind_o, field_id_o, wire_code_o, value_o, status_o,
                          last_result_o);
  end

  // --- message builders: append encoded bytes to msg_q ---

  function automatic logic [63:0] rand_u64();
    return {$urandom, $urandom} >> $urandom_range(0, 63);
  endfunction

  // Append a varint; pad adds non-minimal continuation bytes, up to ten bytes in all.
  function automatic void push_varint(logic [63:0] v, int unsigned pad);
    int unsigned n;
    int unsigned total;
    logic [7:0]  b;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != 0) n++;
    total = (n + pad > 10) ? 10 : n + pad;
    for (int unsigned i = 0; i < total; i++) begin
      b = {1'b0, 7'(v >> (7 * i))};
      if (i + 1 < total) b[7] = 1'b1;
      msg_q.push_back(b);
    end
  endfunction

  function automatic void push_random_bytes(int unsigned n);
    repeat (n) msg_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Ten-byte varint whose last byte carries junk above bit 0.
  function automatic void push_ten_byte_varint();
    repeat (9) msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
    msg_q.push_back(8'($urandom_range(0, 127)));
  endfunction

  // Ten bytes that all continue: one too many for any varint.
  function automatic void push_overlong();
    repeat (10) msg_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
  endfunction

  function automatic logic [60:0] rand_field();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 61'($urandom_range(0, 15));
    if (r < 90) return 61'($urandom_range(16, 32'h1FFF_FFFF));
    return 61'({$urandom, $urandom});
  endfunction

  function automatic void push_key(logic [60:0] fnum, logic [2:0] wt, int unsigned pad);
    push_varint({fnum, wt}, pad);
  endfunction

  function automatic int unsigned rand_pad();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(1, 9) : 0;
  endfunction

  // Append one well-formed field of random kind and content.
  function automatic void add_field();
    logic [2:0]  wt;
    int unsigned len;
    case ($urandom_range(0, 3))
      0:       wt = WT_VARINT;
      1:       wt = WT_FIXED64;
      2:       wt = WT_LEN;
      default: wt = WT_FIXED32;
    endcase
    push_key(rand_field(), wt, rand_pad());
    case (wt)
      WT_VARINT: begin
        if ($urandom_range(0, 9) == 0) push_ten_byte_varint();
        else push_varint(rand_u64(), rand_pad());
      end
      WT_FIXED64: push_random_bytes(8);
      WT_FIXED32: push_random_bytes(4);
      default: begin
        len = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : $urandom_range(7, 40);
        push_varint(64'(len), rand_pad());
        push_random_bytes(len);
      end
    endcase
  endfunction

  // Mostly well-formed messages; the rest cut short, broken or plain noise.
  function automatic void build_random_message();
    int unsigned r;
    int unsigned cut;
    logic [2:0]  bad;
    msg_q.delete();
    repeat ($urandom_range(0, 5)) add_field();
    r = $urandom_range(0, 99);
    if (r < 70) begin
      // leave it well-formed
    end else if (r < 78) begin
      // cut anywhere: inside a key, a value, a length or a payload
      if (msg_q.size() == 0) add_field();
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end else if (r < 84) begin
      case ($urandom_range(0, 3))
        0:       bad = WT_GROUP_START;
        1:       bad = WT_GROUP_END;
        2:       bad = WT_RESERVED6;
        default: bad = WT_RESERVED7;
      endcase
      push_key(rand_field(), bad, 0);
      push_random_bytes($urandom_range(0, 3));
    end else if (r < 90) begin
      // overlong varint as a key, a value or a length
      case ($urandom_range(0, 2))
        0:       ;
        1:       push_key(rand_field(), WT_VARINT, 0);
        default: push_key(rand_field(), WT_LEN, 0);
      endcase
      push_overlong();
      push_random_bytes($urandom_range(0, 3));
    end else if (r < 95) begin
      // length at or just past the room left, or far past it
      push_key(rand_field(), WT_LEN, 0);
      if ($urandom_range(0, 1) == 0)
        push_varint(64'(MAX_MESSAGE_BYTES - msg_q.size() - 3) + 64'($urandom_range(0, 1)), 0);
      else
        push_varint(rand_u64() | 64'(MAX_MESSAGE_BYTES), 0);
      push_random_bytes($urandom_range(0, 3));
    end else begin
      msg_q.delete();
      push_random_bytes($urandom_range(1, 8));
    end
    if (msg_q.size() == 0) push_random_bytes(1);
  endfunction

  // --- drivers ---

  // Present one byte at the falling edge, hold it until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int unsigned gap;
    gap = pick_gap(src_idle);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    byte_in_i   = b;
    last_byte_i = lst;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.take_byte(b, lst);
  endtask

  task automatic send_message();
    for (int unsigned i = 0; i < msg_q.size(); i++)
      send_byte(msg_q[i], i + 1 == msg_q.size());
  endtask

  // Drop valid and hold off until every owed token has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (tracker.tokens_due.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit          paused;
    paused = 1'b0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Every token kind in one clean message, ending on a zero-length field.
    msg_q.delete();
    push_key(61'd1, WT_VARINT, 0);
    push_varint('0, 0);
    push_key(61'd2, WT_FIXED64, 0);
    repeat (8) msg_q.push_back(8'hFF);
    push_key(61'd3, WT_FIXED32, 0);
    msg_q = {msg_q, 8'h00, 8'h00, 8'h00, 8'h80};
    push_key(61'd3, WT_LEN, 0);
    push_varint(64'd1, 0);
    msg_q.push_back(8'hAB);
    push_key(61'd4, WT_LEN, 0);
    push_varint('0, 0);
    send_message();

    // Widest key (field number truncated to all ones) and an all-ones ten-byte value.
    msg_q.delete();
    push_key({61{1'b1}}, WT_VARINT, 0);
    push_varint({64{1'b1}}, 0);
    send_message();
    wait_drained();

    // Random messages; vary idling per message, including stretches with none.
    while (random_sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        src_idle  = 1'b0;
        sink_idle = 1'b0;
      end else begin
        src_idle  = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      build_random_message();
      send_message();
      random_sent += msg_q.size();
      if (!paused && random_sent >= RANDOM_BYTES / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.tokens_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/pwt_pkg.sv
hw/rtl/pwt_front.sv
hw/rtl/pwt_queue.sv
hw/rtl/pwt_back.sv
hw/rtl/protobuf_wire_tokenizer_unit.sv
test/testbench.sv
